// ===== rtl/core/brr_pkg.sv =====
// Package for the rank roulette selector: sizes, constants, sequencer states
// and the request/response structs of the shared divider and multiplier.
// No dependencies.
package brr_pkg;

    localparam int POOL_MAX    = 32;
    localparam int SIG_ENTRIES = 1024;
    localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);
    localparam int POOL_IDX_W  = $clog2(POOL_MAX);
    localparam int CNT_W       = POOL_IDX_W + 1;
    localparam int WEIGHT_W    = 16;
    localparam int TOTAL_W     = WEIGHT_W + POOL_IDX_W;
    localparam int TEMP_W      = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int SERIES_N    = 20;

    localparam logic [TEMP_W-1:0] TEMP_RESET = 10'd200;
    localparam logic [TEMP_W-1:0] COOL_RESET = 10'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_TEMP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_STEP = 1'd1;

    localparam logic [63:0] ONE62 = 64'd1 << 62;
    localparam logic [63:0] ONE46 = 64'd1 << 46;

    // quotient bits per divide job
    localparam logic [6:0] DIV_BITS_INIT = 7'd63;
    localparam logic [6:0] DIV_BITS_RANK = 7'd11;

    typedef enum logic [4:0] {
        ST_INIT_SER,
        ST_INIT_SER_WAIT,
        ST_INIT_TAB,
        ST_INIT_TAB_DIV,
        ST_INIT_TAB_MUL,
        ST_IDLE,
        ST_RB_IX,
        ST_RB_DIV,
        ST_RB_READ,
        ST_RB_WRITE,
        ST_DRAW,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PICK,
        ST_CP_RD,
        ST_CP_WR,
        ST_EMPTY,
        ST_FIN,
        ST_UN_RD,
        ST_UN_EMIT
    } brr_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
        logic [6:0]  nbits;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] product;
    } mul_rsp_t;

endpackage

// ===== rtl/core/brr_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by table build and
// rank-to-index conversion. Depends on brr_pkg.
module brr_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  brr_pkg::div_req_t req,
    output brr_pkg::div_rsp_t rsp
);
    import brr_pkg::*;

    logic [63:0] dvd_reg, dsr_reg, rem_reg, quo_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [6:0]  cnt_m1;
    logic [64:0] trial, diff;
    logic        ge;

    always_comb begin
        cnt_m1 = cnt_reg - 7'd1;
        trial  = {rem_reg, dvd_reg[cnt_m1[5:0]]};
        ge     = trial >= {1'b0, dsr_reg};
        diff   = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
            end else if (busy_reg) begin
                cnt_reg <= cnt_m1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[63:0] : trial[63:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/brr_mulq62.sv =====
// Q2.62 multiplier: four 32x32 partial products formed one after another and
// accumulated, result is bits 125:62 of the full product. Depends on brr_pkg.
module brr_mulq62 (
    input  logic              aclk,
    input  logic              aresetn,
    input  brr_pkg::mul_req_t req,
    output brr_pkg::mul_rsp_t rsp
);
    import brr_pkg::*;

    logic [63:0]  a_reg, b_reg, pp_reg;
    logic [1:0]   pp_sh_reg;
    logic [127:0] acc_reg;
    logic [2:0]   step_reg;
    logic         busy_reg, done_reg;
    logic [31:0]  op_a, op_b;
    logic [1:0]   sh;
    logic [127:0] pp_ext;

    always_comb begin
        case (step_reg)
            3'd0: begin op_a = a_reg[31:0];  op_b = b_reg[31:0];  sh = 2'd0; end
            3'd1: begin op_a = a_reg[63:32]; op_b = b_reg[31:0];  sh = 2'd1; end
            3'd2: begin op_a = a_reg[31:0];  op_b = b_reg[63:32]; sh = 2'd1; end
            3'd3: begin op_a = a_reg[63:32]; op_b = b_reg[63:32]; sh = 2'd2; end
            default: begin op_a = '0; op_b = '0; sh = 2'd0; end
        endcase
        case (pp_sh_reg)
            2'd1:    pp_ext = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_ext = {pp_reg, 64'd0};
            default: pp_ext = {64'd0, pp_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            pp_reg    <= {32'd0, op_a} * {32'd0, op_b};
            pp_sh_reg <= sh;
            if (step_reg != 3'd0)
                acc_reg <= acc_reg + pp_ext;
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg[125:62];

endmodule

// ===== rtl/core/boltzmann_rank_roulette_select.sv =====
// Top level of the rank roulette selector: sequencer, candidate list memory,
// sigmoid table memory and output register. Depends on brr_pkg, brr_div, brr_mulq62.
//
// Usage
//   Requests enter on s_* (valid/ready); each request is one draw and may
//   first rebuild the list (s_start_req) and may close the call (s_finish).
//   Results leave on m_* (valid/ready), one to 32 per request; the last one
//   carries m_last_of_run. Registers are written through cfg_wr_* while
//   idle; the user must keep to this, as the block does not enforce it.
//   One request at a time; s_ready is high only in the idle state.
//   Rebuild: per rank a divide for the table index (none at temperature
//   zero), a table read and a list write that adds the weight to the total.
//   Draw: entries are read and checked in turn up to the pick, then each one
//   behind it moves up in the list. A finish then emits every unselected entry.
// Reset
//   After reset the block builds its 1024-entry sigmoid table on the shared
//   divider and multiplier: 20 series divides, then per entry one divide and
//   one multiply, all with s_ready low.
// Receiver stall
//   The output register holds a result until taken; the sequencer waits
//   before loading the next result, so nothing is dropped or repeated.
module boltzmann_rank_roulette_select (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_start_req,
    input  logic [5:0]                           s_pool_size,
    input  logic [15:0]                          s_rand_fraction,
    input  logic                                 s_finish,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [4:0]                           m_cand_index,
    output logic                                 m_chosen,
    output logic                                 m_empty_error,
    output logic                                 m_last_of_run,
    input  logic                                 cfg_wr_en,
    input  logic [brr_pkg::CFG_IDX_W-1:0]        cfg_wr_index,
    input  logic [brr_pkg::TEMP_W-1:0]           cfg_wr_data
);
    import brr_pkg::*;

    localparam int CAND_W = POOL_IDX_W + WEIGHT_W;

    brr_state_t state_reg, state_next;

    // configuration and temperature
    logic [TEMP_W-1:0] init_temp_reg, cool_reg, temp_reg, temp_next;

    // list bookkeeping
    logic [CNT_W-1:0]   count_reg, count_next, j_reg, j_next;
    logic [TOTAL_W-1:0] total_reg, total_next, target_reg, target_next;
    logic [TOTAL_W-1:0] run_reg, run_next, run_sum;
    logic [SIG_IDX_W-1:0] ix_reg, ix_next;

    // latched request
    logic               start_q_reg, finish_q_reg;
    logic [CNT_W-1:0]   pool_q_reg;
    logic [15:0]        rand_q_reg;
    logic [CNT_W-1:0]   pool_sat;

    // table build
    logic [4:0]  n_reg, n_next;
    logic [63:0] term_reg, term_next, r_reg, r_next, d_reg, d_next;
    logic [SIG_IDX_W-1:0] tab_i_reg, tab_i_next;

    // output register
    logic       m_valid_reg, out_load, out_free;
    logic [4:0] out_idx_reg, out_idx;
    logic       out_ch_reg, out_ch, out_err_reg, out_err, out_last_reg, out_last;

    // memories
    logic [CAND_W-1:0]    cand_mem [POOL_MAX];
    logic [CAND_W-1:0]    cand_rd_data_reg, cand_wdata;
    logic [POOL_IDX_W-1:0] cand_waddr, cand_raddr;
    logic                 cand_we, cand_re;
    logic [WEIGHT_W-1:0]  sig_mem [SIG_ENTRIES];
    logic [WEIGHT_W-1:0]  sig_rd_data_reg, sig_wdata;
    logic [SIG_IDX_W-1:0] sig_waddr, sig_raddr;
    logic                 sig_we, sig_re;

    // shared units
    div_req_t div_req;
    div_rsp_t div_rsp;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    logic [TOTAL_W+15:0] target_prod;
    logic [CNT_W-1:0]    j_inc;
    logic                s_accept;

    brr_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));
    brr_mulq62 u_mul (.aclk(aclk), .aresetn(aresetn), .req(mul_req), .rsp(mul_rsp));

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign pool_sat = (s_pool_size > CNT_W'(POOL_MAX)) ? CNT_W'(POOL_MAX) : s_pool_size;
    assign j_inc    = j_reg + CNT_W'(1);
    assign run_sum  = run_reg + TOTAL_W'(cand_rd_data_reg[WEIGHT_W-1:0]);
    assign target_prod = {{TOTAL_W{1'b0}}, rand_q_reg} * {16'd0, total_reg};

    always_comb begin
        state_next  = state_reg;
        temp_next   = temp_reg;
        count_next  = count_reg;
        j_next      = j_reg;
        total_next  = total_reg;
        target_next = target_reg;
        run_next    = run_reg;
        ix_next     = ix_reg;
        n_next      = n_reg;
        term_next   = term_reg;
        r_next      = r_reg;
        d_next      = d_reg;
        tab_i_next  = tab_i_reg;
        div_req     = '0;
        mul_req     = '0;
        cand_we     = 1'b0;
        cand_waddr  = j_reg[POOL_IDX_W-1:0];
        cand_wdata  = cand_rd_data_reg;
        cand_re     = 1'b0;
        cand_raddr  = j_reg[POOL_IDX_W-1:0];
        sig_we      = 1'b0;
        sig_waddr   = tab_i_reg;
        sig_wdata   = '0;
        sig_re      = 1'b0;
        sig_raddr   = ix_reg;
        out_load    = 1'b0;
        out_idx     = cand_rd_data_reg[CAND_W-1:WEIGHT_W];
        out_ch      = 1'b0;
        out_err     = 1'b0;
        out_last    = 1'b0;

        case (state_reg)
            // exp(-1/64) by its alternating series
            ST_INIT_SER: begin
                div_req.start    = 1'b1;
                div_req.dividend = term_reg;
                div_req.divisor  = {53'd0, n_reg, 6'd0};
                div_req.nbits    = DIV_BITS_INIT;
                state_next       = ST_INIT_SER_WAIT;
            end
            ST_INIT_SER_WAIT: begin
                if (div_rsp.done) begin
                    term_next = div_rsp.quotient;
                    r_next    = n_reg[0] ? r_reg - div_rsp.quotient
                                         : r_reg + div_rsp.quotient;
                    if (n_reg == 5'(SERIES_N)) begin
                        state_next = ST_INIT_TAB;
                    end else begin
                        n_next     = n_reg + 5'd1;
                        state_next = ST_INIT_SER;
                    end
                end
            end
            // sig = 65536*d/(1+d), d = exp(-i/64)
            ST_INIT_TAB: begin
                div_req.start    = 1'b1;
                div_req.dividend = {d_reg[63:16], 16'd0};
                div_req.divisor  = ONE46 + {16'd0, d_reg[63:16]};
                div_req.nbits    = DIV_BITS_INIT;
                state_next       = ST_INIT_TAB_DIV;
            end
            ST_INIT_TAB_DIV: begin
                if (div_rsp.done) begin
                    sig_we      = 1'b1;
                    sig_wdata   = (div_rsp.quotient > 64'd65535) ? 16'hFFFF
                                                                 : div_rsp.quotient[15:0];
                    mul_req.start = 1'b1;
                    mul_req.a     = d_reg;
                    mul_req.b     = r_reg;
                    state_next    = ST_INIT_TAB_MUL;
                end
            end
            ST_INIT_TAB_MUL: begin
                if (mul_rsp.done) begin
                    d_next = mul_rsp.product;
                    if (tab_i_reg == SIG_IDX_W'(SIG_ENTRIES - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        tab_i_next = tab_i_reg + SIG_IDX_W'(1);
                        state_next = ST_INIT_TAB;
                    end
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_start_req) begin
                        count_next = pool_sat;
                        total_next = '0;
                        j_next     = '0;
                        state_next = (pool_sat == '0) ? ST_DRAW : ST_RB_IX;
                    end else begin
                        state_next = ST_DRAW;
                    end
                end
            end
            // rank j -> table index j*64/T, saturated
            ST_RB_IX: begin
                if (temp_reg == '0) begin
                    ix_next    = SIG_IDX_W'(SIG_ENTRIES - 1);
                    state_next = ST_RB_READ;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {52'd0, j_reg, 6'd0};
                    div_req.divisor  = {54'd0, temp_reg};
                    div_req.nbits    = DIV_BITS_RANK;
                    state_next       = ST_RB_DIV;
                end
            end
            ST_RB_DIV: begin
                if (div_rsp.done) begin
                    ix_next = (div_rsp.quotient > 64'(SIG_ENTRIES - 1))
                            ? SIG_IDX_W'(SIG_ENTRIES - 1)
                            : div_rsp.quotient[SIG_IDX_W-1:0];
                    state_next = ST_RB_READ;
                end
            end
            ST_RB_READ: begin
                sig_re     = 1'b1;
                state_next = ST_RB_WRITE;
            end
            ST_RB_WRITE: begin
                cand_we    = 1'b1;
                cand_wdata = {j_reg[POOL_IDX_W-1:0], sig_rd_data_reg};
                total_next = total_reg + TOTAL_W'(sig_rd_data_reg);
                j_next     = j_inc;
                state_next = (j_inc == count_reg) ? ST_DRAW : ST_RB_IX;
            end
            ST_DRAW: begin
                if (count_reg == '0) begin
                    state_next = ST_EMPTY;
                end else begin
                    target_next = target_prod[TOTAL_W+15:16];
                    j_next      = '0;
                    run_next    = '0;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                cand_re    = 1'b1;
                state_next = ST_SCAN_CHK;
            end
            // first entry whose running sum reaches the target, else the last
            ST_SCAN_CHK: begin
                if (run_sum >= target_reg || j_inc == count_reg) begin
                    state_next = ST_PICK;
                end else begin
                    run_next   = run_sum;
                    j_next     = j_inc;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_PICK: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_ch     = 1'b1;
                    out_last   = !(finish_q_reg && count_reg > CNT_W'(1));
                    total_next = total_reg - TOTAL_W'(cand_rd_data_reg[WEIGHT_W-1:0]);
                    state_next = ST_CP_RD;
                end
            end
            // close the gap left by the pick
            ST_CP_RD: begin
                if (j_inc >= count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_FIN;
                end else begin
                    cand_re    = 1'b1;
                    cand_raddr = j_inc[POOL_IDX_W-1:0];
                    state_next = ST_CP_WR;
                end
            end
            ST_CP_WR: begin
                cand_we    = 1'b1;
                j_next     = j_inc;
                state_next = ST_CP_RD;
            end
            ST_EMPTY: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_idx    = '0;
                    out_err    = 1'b1;
                    out_last   = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                j_next     = '0;
                state_next = finish_q_reg ? ST_UN_RD : ST_IDLE;
            end
            ST_UN_RD: begin
                if (j_reg >= count_reg) begin
                    count_next = '0;
                    total_next = '0;
                    if (temp_reg > cool_reg)
                        temp_next = temp_reg - cool_reg;
                    state_next = ST_IDLE;
                end else begin
                    cand_re    = 1'b1;
                    state_next = ST_UN_EMIT;
                end
            end
            ST_UN_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = (j_inc == count_reg);
                    j_next     = j_inc;
                    state_next = ST_UN_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT_SER;
            init_temp_reg <= TEMP_RESET;
            cool_reg      <= COOL_RESET;
            temp_reg      <= TEMP_RESET;
            count_reg     <= '0;
            total_reg     <= '0;
            n_reg         <= 5'd1;
            term_reg      <= ONE62;
            r_reg         <= ONE62;
            d_reg         <= ONE62;
            tab_i_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            n_reg     <= n_next;
            term_reg  <= term_next;
            r_reg     <= r_next;
            d_reg     <= d_next;
            tab_i_reg <= tab_i_next;
            temp_reg  <= temp_next;
            if (cfg_wr_en && cfg_wr_index == CFG_INIT_TEMP) begin
                init_temp_reg <= cfg_wr_data;
                temp_reg      <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_wr_index == CFG_COOL_STEP)
                cool_reg <= cfg_wr_data;
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        j_reg      <= j_next;
        target_reg <= target_next;
        run_reg    <= run_next;
        ix_reg     <= ix_next;
        if (s_accept) begin
            start_q_reg  <= s_start_req;
            finish_q_reg <= s_finish;
            pool_q_reg   <= pool_sat;
            rand_q_reg   <= s_rand_fraction;
        end
        if (out_load) begin
            out_idx_reg  <= out_idx;
            out_ch_reg   <= out_ch;
            out_err_reg  <= out_err;
            out_last_reg <= out_last;
        end
    end

    // candidate list and sigmoid table
    always_ff @(posedge aclk) begin
        if (cand_we)
            cand_mem[cand_waddr] <= cand_wdata;
        if (cand_re)
            cand_rd_data_reg <= cand_mem[cand_raddr];
        if (sig_we)
            sig_mem[sig_waddr] <= sig_wdata;
        if (sig_re)
            sig_rd_data_reg <= sig_mem[sig_raddr];
    end

    assign m_valid       = m_valid_reg;
    assign m_cand_index  = out_idx_reg;
    assign m_chosen      = out_ch_reg;
    assign m_empty_error = out_err_reg;
    assign m_last_of_run = out_last_reg;

    // list never grows past the pool limit
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(POOL_MAX))
        else $error("candidate count above pool limit");

    // one request at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // divider is never restarted mid-job
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // an empty draw is a lone, unchosen result
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_error |-> m_last_of_run && !m_chosen)
        else $error("empty result not final");

    // a recorded start request skips the rebuild only when its pool size is zero
    a_pool_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        start_q_reg && state_reg == ST_DRAW && $past(state_reg) == ST_IDLE
        |-> pool_q_reg == '0)
        else $error("rebuild skipped for nonempty pool");

endmodule
